### design/circle_path_follow_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Circle path follow controller: assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PATH_FOLLOW_CONTROLLER_TOP_DEFINES_SVH
`define CIRCLE_PATH_FOLLOW_CONTROLLER_TOP_DEFINES_SVH

// condition must hold at every edge
`define CPF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/cpf_pkg.sv
// ----------------------------------------------------------------------------
// Circle path follow controller package
// Fixed-point constants, sequencer types and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpf_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int MUL_W        = 36;
	localparam int DIV_W        = 32 + FRAC_BITS;
	localparam int CFG_IDX_W    = 3;

	// pi/180 in Q32, angle constants in Q30
	localparam logic signed [MUL_W-1:0] DEG2RAD_Q32 = 36'sd74961321;
	localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [34:0] ONE_Q30      = 35'sd1073741824;

	// heading wrap limits, degrees in Q16.16
	localparam logic signed [25:0] DEG180 = 26'sd180 <<< FRAC_BITS;
	localparam logic signed [25:0] DEG360 = 26'sd360 <<< FRAC_BITS;

	localparam logic signed [79:0] S32_MAX = 80'sd2147483647;
	localparam logic signed [79:0] S32_MIN = -80'sd2147483648;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_VEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CT_KP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CT_KD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AT_KP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AT_KI   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_KP  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_KI  = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_MUL, S_USE, S_CORDIC, S_DIV, S_OUT
	} state_t;

	// multiplier program, one product each
	typedef enum logic [4:0] {
		ST_ANGLE, ST_GOAL_X, ST_GOAL_Y, ST_PEX_C, ST_PEX_S, ST_PVX_C, ST_PVX_S,
		ST_PVY_S, ST_PVY_C, ST_RATE, ST_INT_AT, ST_INT_ANG, ST_FWD_P, ST_FWD_D,
		ST_LAT_P, ST_LAT_I, ST_TURN_P, ST_TURN_I
	} step_t;

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		if (v > S32_MAX) return 32'sh7fffffff;
		if (v < S32_MIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	// arctan(2^-i) in Q30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		unique case (i)
			5'd0:  return 34'sd843314857;
			5'd1:  return 34'sd497837829;
			5'd2:  return 34'sd263043837;
			5'd3:  return 34'sd133525159;
			5'd4:  return 34'sd67021687;
			5'd5:  return 34'sd33543516;
			5'd6:  return 34'sd16775851;
			5'd7:  return 34'sd8388437;
			5'd8:  return 34'sd4194283;
			5'd9:  return 34'sd2097149;
			5'd10: return 34'sd1048576;
			5'd11: return 34'sd524288;
			5'd12: return 34'sd262144;
			5'd13: return 34'sd131072;
			5'd14: return 34'sd65536;
			5'd15: return 34'sd32768;
			5'd16: return 34'sd16384;
			5'd17: return 34'sd8192;
			5'd18: return 34'sd4096;
			5'd19: return 34'sd2048;
			5'd20: return 34'sd1024;
			5'd21: return 34'sd512;
			5'd22: return 34'sd256;
			5'd23: return 34'sd128;
			default: return 34'sd0;
		endcase
	endfunction

endpackage

### design/circle_path_follow_controller_top.sv
// Circle path follow controller: usage
// Input channel s_axis carries one pose sample per item; output channel m_axis
// returns one command item (forward, lateral, turn) per sample. The plain
// write port (cfg_we, cfg_index, cfg_data) loads radius, target velocity and
// the six gains; write it only while the block is idle.
// The first sample after reset is latched as the circle origin.
// The work from accept to result is done by one shared 36x36 multiplier
// that runs an 18-product program, the CORDIC rotator (one step a cycle)
// and a radix-2 divider (one quotient bit a cycle).
// One item is in flight at a time: s_axis_tready is high only when idle,
// so a new sample is taken only after the last result has left m_axis.
// When the receiver stalls, the result holds on m_axis and no new sample
// is taken. Reset (arst_n low) clears origin, integrators, previous errors
// and restores radius 1.0 with all gains zero.
// ----------------------------------------------------------------------------
// Circle path follow controller top
// Sequencer with shared multiplier, CORDIC and divider for three gain channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circle_path_follow_controller_top_defines.svh"

module circle_path_follow_controller_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x, pos_y, heading_deg, vel_x, vel_y, heading_rate_deg, elapsed, pad
	input  logic [223:0]                     s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// cmd_forward, cmd_lateral, cmd_turn
	output logic [95:0]                      m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [cpf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);
	import cpf_pkg::*;

	state_t state_q, state_d;
	step_t  step_q;
	logic [5:0] cnt_q;

	// configuration
	logic [30:0] rad_q;
	logic signed [31:0] lat_vel_q, ct_kp_q, ct_kd_q, at_kp_q, at_ki_q, ang_kp_q, ang_ki_q;

	// persistent state
	logic origin_valid_q;
	logic signed [31:0] ox_q, oy_q;
	logic signed [24:0] oh_q;
	logic signed [31:0] aint_q, tint_q, prev_at_q, prev_ang_q;

	// sample registers
	logic signed [31:0] px_q, py_q, vx_q, vy_q, rate_q;
	logic signed [24:0] hd_q;
	logic [31:0] dt_q;

	// working registers
	logic signed [25:0] rel_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic neg_q;
	logic signed [31:0] ex_q, ey_q, pex_q, pvx_q, pvy_q, e2_q;
	logic signed [31:0] fwd_q, lat_q, turn_q;
	logic signed [79:0] acc_q;
	logic signed [2*MUL_W-1:0] p_q;
	logic [DIV_W-1:0] dvd_q;
	logic [31:0] rem_q;
	logic dneg_q;

	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {turn_q, lat_q, fwd_q};

	// sine and cosine after the fold
	logic signed [33:0] sin_v, cos_v;
	assign sin_v = neg_q ? -y_q : y_q;
	assign cos_v = neg_q ? -x_q : x_q;

	// derived errors
	logic signed [31:0] e0_v, e1_v;
	assign e0_v = sat32(-80'(pvx_q));
	assign e1_v = sat32(80'(lat_vel_q) - 80'(pvy_q));

	// multiplier operand select
	logic signed [MUL_W-1:0] op_a, op_b;
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			ST_ANGLE:   begin op_a = MUL_W'(rel_q);  op_b = DEG2RAD_Q32; end
			ST_GOAL_X:  begin op_a = MUL_W'({1'b0, rad_q}); op_b = MUL_W'(ONE_Q30 - 35'(cos_v)); end
			ST_GOAL_Y:  begin op_a = MUL_W'({1'b0, rad_q}); op_b = MUL_W'(sin_v); end
			ST_PEX_C:   begin op_a = MUL_W'(ex_q);   op_b = MUL_W'(cos_v); end
			ST_PEX_S:   begin op_a = MUL_W'(ey_q);   op_b = MUL_W'(sin_v); end
			ST_PVX_C:   begin op_a = MUL_W'(vx_q);   op_b = MUL_W'(cos_v); end
			ST_PVX_S:   begin op_a = MUL_W'(vy_q);   op_b = MUL_W'(sin_v); end
			ST_PVY_S:   begin op_a = MUL_W'(vx_q);   op_b = MUL_W'(sin_v); end
			ST_PVY_C:   begin op_a = MUL_W'(vy_q);   op_b = MUL_W'(cos_v); end
			ST_RATE:    begin op_a = MUL_W'(rate_q); op_b = DEG2RAD_Q32; end
			ST_INT_AT:  begin op_a = MUL_W'(prev_at_q);  op_b = MUL_W'({1'b0, dt_q}); end
			ST_INT_ANG: begin op_a = MUL_W'(prev_ang_q); op_b = MUL_W'({1'b0, dt_q}); end
			ST_FWD_P:   begin op_a = MUL_W'(pex_q);  op_b = MUL_W'(ct_kp_q); end
			ST_FWD_D:   begin op_a = MUL_W'(e0_v);   op_b = MUL_W'(ct_kd_q); end
			ST_LAT_P:   begin op_a = MUL_W'(e1_v);   op_b = MUL_W'(at_kp_q); end
			ST_LAT_I:   begin op_a = MUL_W'(aint_q); op_b = MUL_W'(at_ki_q); end
			ST_TURN_P:  begin op_a = MUL_W'(e2_q);   op_b = MUL_W'(ang_kp_q); end
			ST_TURN_I:  begin op_a = MUL_W'(tint_q); op_b = MUL_W'(ang_ki_q); end
			default:    begin op_a = '0; op_b = '0; end
		endcase
	end

	// shifted views of the registered product
	logic signed [79:0] p80, shr16, shr18, shr30, shr32;
	assign p80   = 80'(p_q);
	assign shr16 = p80 >>> FRAC_BITS;
	assign shr18 = p80 >>> (FRAC_BITS + 2);
	assign shr30 = p80 >>> 30;
	assign shr32 = p80 >>> 32;

	logic signed [33:0] zraw;
	assign zraw = 34'(shr18);

	logic signed [31:0] pvy_nx;
	assign pvy_nx = sat32((acc_q + p80) >>> 30);

	// divider trial subtract
	logic [31:0] dvs;
	logic [32:0] trial;
	logic ge;
	assign dvs   = (rad_q == '0) ? 32'd1 : {1'b0, rad_q};
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, dvs});

	logic signed [31:0] ang_vel;
	assign ang_vel = sat32(dneg_q ? -80'({1'b0, dvd_q}) : 80'({1'b0, dvd_q}));

	// CORDIC step terms
	logic signed [33:0] dx, dy, at_v;
	assign dx   = y_q >>> cnt_q[4:0];
	assign dy   = x_q >>> cnt_q[4:0];
	assign at_v = atan_q30(cnt_q[4:0]);

	// heading relative to origin, single wrap
	logic signed [25:0] rel_raw, rel_wr;
	always_comb begin
		rel_raw = 26'(hd_q) - 26'(oh_q);
		if (rel_raw < -DEG180) rel_wr = rel_raw + DEG360;
		else if (rel_raw >= DEG180) rel_wr = rel_raw - DEG360;
		else rel_wr = rel_raw;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_d = S_PREP;
			S_PREP:   state_d = S_MUL;
			S_MUL:    state_d = S_USE;
			S_USE: begin
				if (step_q == ST_ANGLE) state_d = S_CORDIC;
				else if (step_q == ST_PVY_C) state_d = S_DIV;
				else if (step_q == ST_TURN_I) state_d = S_OUT;
				else state_d = S_MUL;
			end
			S_CORDIC: if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = S_MUL;
			S_DIV:    if (cnt_q == 6'(DIV_W - 1)) state_d = S_MUL;
			S_OUT:    if (m_axis_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q     <= 31'd65536;
			lat_vel_q <= '0;
			ct_kp_q   <= '0;
			ct_kd_q   <= '0;
			at_kp_q   <= '0;
			at_ki_q   <= '0;
			ang_kp_q  <= '0;
			ang_ki_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS:  rad_q     <= cfg_data[30:0];
				REG_LAT_VEL: lat_vel_q <= cfg_data;
				REG_CT_KP:   ct_kp_q   <= cfg_data;
				REG_CT_KD:   ct_kd_q   <= cfg_data;
				REG_AT_KP:   at_kp_q   <= cfg_data;
				REG_AT_KI:   at_ki_q   <= cfg_data;
				REG_ANG_KP:  ang_kp_q  <= cfg_data;
				REG_ANG_KI:  ang_ki_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// controller state and sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= ST_ANGLE;
			cnt_q          <= '0;
			origin_valid_q <= 1'b0;
			ox_q           <= '0;
			oy_q           <= '0;
			oh_q           <= '0;
			aint_q         <= '0;
			tint_q         <= '0;
			prev_at_q      <= '0;
			prev_ang_q     <= '0;
		end else begin
			if (accept) begin
				step_q <= ST_ANGLE;
				if (!origin_valid_q) begin
					origin_valid_q <= 1'b1;
					ox_q <= s_axis_tdata[31:0];
					oy_q <= s_axis_tdata[63:32];
					oh_q <= s_axis_tdata[88:64];
				end
			end
			if (state_q == S_CORDIC || state_q == S_DIV) cnt_q <= cnt_q + 6'd1;
			if (state_q == S_USE) begin
				cnt_q <= '0;
				if (step_q != ST_TURN_I) step_q <= step_t'(step_q + 5'd1);
				unique case (step_q)
					ST_INT_AT:  aint_q <= sat32(80'(aint_q) + shr16);
					ST_INT_ANG: tint_q <= sat32(80'(tint_q) + shr16);
					ST_TURN_I: begin
						prev_at_q  <= e1_v;
						prev_ang_q <= e2_q;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= s_axis_tdata[31:0];
			py_q   <= s_axis_tdata[63:32];
			hd_q   <= s_axis_tdata[88:64];
			vx_q   <= s_axis_tdata[120:89];
			vy_q   <= s_axis_tdata[152:121];
			rate_q <= s_axis_tdata[184:153];
			dt_q   <= s_axis_tdata[216:185];
		end
		if (state_q == S_PREP) rel_q <= rel_wr;
		if (state_q == S_MUL) p_q <= op_a * op_b;
		// CORDIC rotation step
		if (state_q == S_CORDIC) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at_v;
			end
		end
		// restoring divide, one quotient bit
		if (state_q == S_DIV) begin
			rem_q <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
		if (state_q == S_USE) begin
			unique case (step_q)
				ST_ANGLE: begin
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					if (zraw > HALF_PI_Q30) begin
						z_q <= zraw - PI_Q30;
						neg_q <= 1'b1;
					end else if (zraw < -HALF_PI_Q30) begin
						z_q <= zraw + PI_Q30;
						neg_q <= 1'b1;
					end else begin
						z_q <= zraw;
						neg_q <= 1'b0;
					end
				end
				ST_GOAL_X: ex_q <= sat32(80'(ox_q) + shr30 - 80'(px_q));
				ST_GOAL_Y: ey_q <= sat32(80'(oy_q) - shr30 - 80'(py_q));
				ST_PEX_C:  acc_q <= p80;
				ST_PEX_S:  pex_q <= sat32((acc_q + p80) >>> 30);
				ST_PVX_C:  acc_q <= p80;
				ST_PVX_S:  pvx_q <= sat32((acc_q + p80) >>> 30);
				ST_PVY_S:  acc_q <= -p80;
				ST_PVY_C: begin
					pvy_q  <= pvy_nx;
					rem_q  <= '0;
					dneg_q <= !pvy_nx[31] && (pvy_nx != '0);
					dvd_q  <= {(pvy_nx[31] ? (~pvy_nx + 32'd1) : pvy_nx), FRAC_BITS'(0)};
				end
				ST_RATE:   e2_q  <= sat32(80'(ang_vel) - shr32);
				ST_FWD_P:  acc_q <= shr16;
				ST_FWD_D:  fwd_q <= sat32(acc_q + shr16);
				ST_LAT_P:  acc_q <= shr16;
				ST_LAT_I:  lat_q <= sat32(acc_q + shr16);
				ST_TURN_P: acc_q <= shr16;
				ST_TURN_I: turn_q <= sat32(acc_q + shr16);
				default: ;
			endcase
		end
	end

	`CPF_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "accepting while result pending")
	`CPF_ASSERT_NEXT(a_accept_prep, accept, state_q == S_PREP, "accept did not start work")
	`CPF_ASSERT_NEXT(a_origin_set, accept, origin_valid_q, "origin not latched")
	`CPF_ASSERT(a_cordic_cnt, (state_q != S_CORDIC) || (cnt_q < 6'(CORDIC_STEPS)), "CORDIC overrun")

endmodule
